// ===== hdl/rvu_pkg.sv =====
// ----------------------------------------------------------------------------
// rvu_pkg
// shared constants of the refraction vector unit: port width and the
// default fraction width of the fixed point formats
// ----------------------------------------------------------------------------
package rvu_pkg;

    localparam int RVU_DW        = 16;
    localparam int RVU_FRAC_BITS = 14;

endpackage

// ===== hdl/refraction_vector_unit.sv =====
// ----------------------------------------------------------------------------
// refraction_vector_unit
// snell refraction of a unit ray direction at a surface with outward normal
// and index of refraction, fixed point, fully pipelined
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  request   start / busy       dir_x dir_y dir_z norm_x norm_y norm_z refr_index
//  result    done (one cycle)   out_x out_y out_z total_reflect exiting
//
//  one request per cycle, busy stays low; each result passes the NS stages and
//  the output registers, NS = 2 * FRAC_BITS + max(FRAC_BITS + 1, MW) + 14
//  (three square roots and two restoring dividers, one bit a stage)
//  reset clears the stage valid bits and the result strobe only
//  the result side cannot stall, so the pipeline never holds
// ----------------------------------------------------------------------------
module refraction_vector_unit
    import rvu_pkg::*;
#(
    parameter int FRAC_BITS = RVU_FRAC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [RVU_DW-1:0] dir_x,
    input  logic signed [RVU_DW-1:0] dir_y,
    input  logic signed [RVU_DW-1:0] dir_z,
    input  logic signed [RVU_DW-1:0] norm_x,
    input  logic signed [RVU_DW-1:0] norm_y,
    input  logic signed [RVU_DW-1:0] norm_z,
    input  logic        [RVU_DW-1:0] refr_index,
    output logic                     done,
    output logic signed [RVU_DW-1:0] out_x,
    output logic signed [RVU_DW-1:0] out_y,
    output logic signed [RVU_DW-1:0] out_z,
    output logic                     total_reflect,
    output logic                     exiting
);

    localparam int F   = FRAC_BITS;
    localparam int MW  = (48 - 2 * F > 16) ? 50 - 2 * F : 18;
    localparam int QW  = 2 * MW;
    localparam int RW1 = 2 * F + 2;
    localparam int R1  = F + 1;
    localparam int NW  = (2 * F + 2 > F + 16) ? 2 * F + 2 : F + 16;
    localparam int TW  = F + MW + 1;
    localparam int RDW = ((2 * F > 50) ? 2 * F : 50) + 1;
    localparam int OW  = ((F + 2 > 18) ? F + 2 : 18) + 1;
    localparam int EW  = F + 18;
    localparam int PW  = F + 17;
    localparam int N1  = (R1 > MW) ? R1 : MW;

    localparam int ST_MUL = 1;
    localparam int ST_DOT = 2;
    localparam int ST_C1  = 3;
    localparam int ST_M   = 4;
    localparam int ST_SQ  = 5;
    localparam int ST_SUM = 6;
    localparam int SQ1_0  = 7;
    localparam int ST_S2A = SQ1_0 + N1;
    localparam int ST_S2B = ST_S2A + 1;
    localparam int DV1_0  = ST_S2B + 1;
    localparam int ST_S2  = DV1_0 + F;
    localparam int ST_SQR = ST_S2 + 1;
    localparam int ST_PRE = ST_SQR + 1;
    localparam int SQ2_0  = ST_PRE + 1;
    localparam int ST_NP  = SQ2_0 + R1;
    localparam int NS     = ST_NP + 1;

    localparam logic [RW1-1:0] ONE_SQ = RW1'(1) << (2 * F);
    localparam logic [32:0]    HALF33 = 33'(1) << (F - 1);
    localparam logic [32:0]    ONE33  = 33'(1) << F;
    localparam logic [RDW-1:0] HALF2  = RDW'(1) << (2 * F - 1);
    localparam logic [EW-1:0]  HALFE  = EW'(1) << (F - 1);
    localparam logic [EW-1:0]  ONEE   = EW'(1) << F;
    localparam logic [PW-1:0]  HALFP  = PW'(1) << (F - 1);
    localparam logic signed [OW-1:0] SAT_HI = OW'(32767);
    localparam logic signed [OW-1:0] SAT_LO = OW'(-32768);

    typedef struct packed {
        logic [2:0][15:0]     d;
        logic [2:0][15:0]     n;
        logic [15:0]          ior;
        logic [2:0][31:0]     prod;
        logic [33:0]          dot;
        logic                 ext;
        logic                 c1_big;
        logic [F-1:0]         c1;
        logic [2:0][49:0]     dn;
        logic [2:0][MW-1:0]   m;
        logic [2:0][QW-1:0]   mm;
        logic [RW1-1:0]       a_rad;
        logic [R1+1:0]        a_rem;
        logic [R1-1:0]        a_root;
        logic [QW-1:0]        b_rad;
        logic [MW+1:0]        b_rem;
        logic [MW-1:0]        b_root;
        logic [R1-1:0]        s1;
        logic [MW-1:0]        len;
        logic [EW-1:0]        ex_sum;
        logic [NW-1:0]        drem;
        logic [F-1:0]         dq;
        logic                 tir;
        logic [F-1:0]         s2;
        logic [2*F-1:0]       s2sq;
        logic [2:0][F+MW-1:0] tp;
        logic [2:0][TW-1:0]   trem;
        logic [2:0][F-1:0]    tq;
        logic [2:0]           tneg;
        logic [2:0][PW-1:0]   np;
    } ctx_t;

    ctx_t             pipe_reg  [NS];
    ctx_t             pipe_next [NS];
    logic [NS-1:0]    valid_reg;

    logic                    done_reg;
    logic signed [15:0]      out_x_reg;
    logic signed [15:0]      out_y_reg;
    logic signed [15:0]      out_z_reg;
    logic                    total_reflect_reg;
    logic                    exiting_reg;
    logic [2:0][15:0]        out_next;

    function automatic ctx_t sqrt_a_step(ctx_t c);
        logic [R1+3:0] rem2;
        logic [R1+3:0] t;
        rem2 = {c.a_rem, c.a_rad[RW1-1 -: 2]};
        t    = {2'b00, c.a_root, 2'b01};
        if (rem2 >= t)
        begin
            c.a_rem  = (R1 + 2)'(rem2 - t);
            c.a_root = {c.a_root[R1-2:0], 1'b1};
        end
        else
        begin
            c.a_rem  = (R1 + 2)'(rem2);
            c.a_root = {c.a_root[R1-2:0], 1'b0};
        end
        c.a_rad = c.a_rad << 2;
        return c;
    endfunction

    function automatic ctx_t sqrt_b_step(ctx_t c);
        logic [MW+3:0] rem2;
        logic [MW+3:0] t;
        rem2 = {c.b_rem, c.b_rad[QW-1 -: 2]};
        t    = {2'b00, c.b_root, 2'b01};
        if (rem2 >= t)
        begin
            c.b_rem  = (MW + 2)'(rem2 - t);
            c.b_root = {c.b_root[MW-2:0], 1'b1};
        end
        else
        begin
            c.b_rem  = (MW + 2)'(rem2);
            c.b_root = {c.b_root[MW-2:0], 1'b0};
        end
        c.b_rad = c.b_rad << 2;
        return c;
    endfunction

    assign busy = 1'b0;

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        if (k == 0)
        begin : g_in
            always_comb
            begin
                pipe_next[k]      = '0;
                pipe_next[k].d[0] = dir_x;
                pipe_next[k].d[1] = dir_y;
                pipe_next[k].d[2] = dir_z;
                pipe_next[k].n[0] = norm_x;
                pipe_next[k].n[1] = norm_y;
                pipe_next[k].n[2] = norm_z;
                pipe_next[k].ior  = refr_index;
            end
        end
        else if (k == ST_MUL)
        begin : g_mul
            always_comb
            begin
                pipe_next[k] = pipe_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    pipe_next[k].prod[i] = 32'($signed(pipe_reg[k-1].d[i]))
                                         * 32'($signed(pipe_reg[k-1].n[i]));
                end
                // zero index counts as one lsb
                if (pipe_reg[k-1].ior == 16'd0)
                begin
                    pipe_next[k].ior = 16'd1;
                end
            end
        end
        else if (k == ST_DOT)
        begin : g_dot
            always_comb
            begin
                pipe_next[k]     = pipe_reg[k-1];
                pipe_next[k].dot = 34'($signed(pipe_reg[k-1].prod[0]))
                                 + 34'($signed(pipe_reg[k-1].prod[1]))
                                 + 34'($signed(pipe_reg[k-1].prod[2]));
                pipe_next[k].ext = ~pipe_next[k].dot[33];
            end
        end
        else if (k == ST_C1)
        begin : g_c1
            always_comb
            begin
                logic [33:0] adot;
                logic [32:0] c1f;
                pipe_next[k] = pipe_reg[k-1];
                adot = pipe_reg[k-1].dot[33] ? -pipe_reg[k-1].dot : pipe_reg[k-1].dot;
                c1f  = (adot[32:0] + HALF33) >> F;
                pipe_next[k].c1_big = c1f >= ONE33;
                pipe_next[k].c1     = c1f[F-1:0];
                for (int i = 0; i < 3; i++)
                begin
                    pipe_next[k].dn[i] = 50'($signed(pipe_reg[k-1].dot))
                                       * 50'($signed(pipe_reg[k-1].n[i]));
                end
            end
        end
        else if (k == ST_M)
        begin : g_m
            always_comb
            begin
                logic [2*F-1:0]        c1sq;
                logic [49:0]           mag;
                logic [RDW-1:0]        rs;
                logic signed [MW-1:0]  rq;
                pipe_next[k] = pipe_reg[k-1];
                c1sq = (2 * F)'(pipe_reg[k-1].c1) * (2 * F)'(pipe_reg[k-1].c1);
                pipe_next[k].a_rad  = pipe_reg[k-1].c1_big ? '0 : ONE_SQ - RW1'(c1sq);
                pipe_next[k].a_rem  = '0;
                pipe_next[k].a_root = '0;
                for (int i = 0; i < 3; i++)
                begin
                    mag = pipe_reg[k-1].dn[i][49] ? -pipe_reg[k-1].dn[i]
                                                  : pipe_reg[k-1].dn[i];
                    rs  = RDW'(mag) + HALF2;
                    rq  = MW'(rs >> (2 * F));
                    if (pipe_reg[k-1].dn[i][49])
                    begin
                        rq = -rq;
                    end
                    pipe_next[k].m[i] = MW'($signed(pipe_reg[k-1].d[i])) - rq;
                end
            end
        end
        else if (k == ST_SQ)
        begin : g_sq
            always_comb
            begin
                pipe_next[k] = pipe_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    pipe_next[k].mm[i] = QW'($signed(pipe_reg[k-1].m[i]))
                                       * QW'($signed(pipe_reg[k-1].m[i]));
                end
            end
        end
        else if (k == ST_SUM)
        begin : g_sum
            always_comb
            begin
                pipe_next[k]        = pipe_reg[k-1];
                pipe_next[k].b_rad  = pipe_reg[k-1].mm[0] + pipe_reg[k-1].mm[1]
                                    + pipe_reg[k-1].mm[2];
                pipe_next[k].b_rem  = '0;
                pipe_next[k].b_root = '0;
            end
        end
        else if (k < ST_S2A)
        begin : g_sqrt1
            localparam int J = k - SQ1_0;
            always_comb
            begin
                pipe_next[k] = pipe_reg[k-1];
                if (J < R1)
                begin
                    pipe_next[k] = sqrt_a_step(pipe_next[k]);
                end
                if (J < MW)
                begin
                    pipe_next[k] = sqrt_b_step(pipe_next[k]);
                end
            end
        end
        else if (k == ST_S2A)
        begin : g_s2a
            always_comb
            begin
                pipe_next[k]        = pipe_reg[k-1];
                pipe_next[k].s1     = pipe_reg[k-1].a_root;
                pipe_next[k].len    = pipe_reg[k-1].b_root;
                pipe_next[k].ex_sum = EW'(pipe_reg[k-1].a_root) * EW'(pipe_reg[k-1].ior)
                                    + HALFE;
                pipe_next[k].drem   = (NW'(pipe_reg[k-1].a_root) << F)
                                    + NW'(pipe_reg[k-1].ior >> 1);
                pipe_next[k].dq     = '0;
            end
        end
        else if (k == ST_S2B)
        begin : g_s2b
            always_comb
            begin
                pipe_next[k] = pipe_reg[k-1];
                if (pipe_reg[k-1].ext)
                begin
                    pipe_next[k].tir = (pipe_reg[k-1].ex_sum >> F) >= ONEE;
                end
                else
                begin
                    pipe_next[k].tir = pipe_reg[k-1].drem >= (NW'(pipe_reg[k-1].ior) << F);
                end
            end
        end
        else if (k < ST_S2)
        begin : g_div1
            localparam int B = F - 1 - (k - DV1_0);
            always_comb
            begin
                logic [NW-1:0] sub;
                pipe_next[k] = pipe_reg[k-1];
                sub = NW'(pipe_reg[k-1].ior) << B;
                if (pipe_reg[k-1].drem >= sub)
                begin
                    pipe_next[k].drem  = pipe_reg[k-1].drem - sub;
                    pipe_next[k].dq[B] = 1'b1;
                end
            end
        end
        else if (k == ST_S2)
        begin : g_s2
            always_comb
            begin
                pipe_next[k]    = pipe_reg[k-1];
                pipe_next[k].s2 = pipe_reg[k-1].ext ? F'(pipe_reg[k-1].ex_sum >> F)
                                                    : pipe_reg[k-1].dq;
            end
        end
        else if (k == ST_SQR)
        begin : g_sqr
            always_comb
            begin
                pipe_next[k]      = pipe_reg[k-1];
                pipe_next[k].s2sq = (2 * F)'(pipe_reg[k-1].s2) * (2 * F)'(pipe_reg[k-1].s2);
                for (int i = 0; i < 3; i++)
                begin
                    pipe_next[k].tp[i] = (F + MW)'($signed({1'b0, pipe_reg[k-1].s2}))
                                       * (F + MW)'($signed(pipe_reg[k-1].m[i]));
                end
            end
        end
        else if (k == ST_PRE)
        begin : g_pre
            always_comb
            begin
                logic [F+MW-1:0] mag;
                pipe_next[k]        = pipe_reg[k-1];
                pipe_next[k].a_rad  = ONE_SQ - RW1'(pipe_reg[k-1].s2sq);
                pipe_next[k].a_rem  = '0;
                pipe_next[k].a_root = '0;
                for (int i = 0; i < 3; i++)
                begin
                    pipe_next[k].tneg[i] = pipe_reg[k-1].tp[i][F+MW-1];
                    mag = pipe_reg[k-1].tp[i][F+MW-1] ? -pipe_reg[k-1].tp[i]
                                                      : pipe_reg[k-1].tp[i];
                    pipe_next[k].trem[i] = TW'(mag) + TW'(pipe_reg[k-1].len >> 1);
                    pipe_next[k].tq[i]   = '0;
                end
            end
        end
        else if (k < ST_NP)
        begin : g_sqrt2
            localparam int J = k - SQ2_0;
            localparam int B = (J < F) ? F - 1 - J : 0;
            always_comb
            begin
                logic [TW-1:0] sub;
                pipe_next[k] = sqrt_a_step(pipe_reg[k-1]);
                sub = TW'(pipe_reg[k-1].len) << B;
                if (J < F)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (pipe_reg[k-1].trem[i] >= sub)
                        begin
                            pipe_next[k].trem[i]  = pipe_reg[k-1].trem[i] - sub;
                            pipe_next[k].tq[i][B] = 1'b1;
                        end
                    end
                end
            end
        end
        else
        begin : g_np
            always_comb
            begin
                pipe_next[k] = pipe_reg[k-1];
                for (int i = 0; i < 3; i++)
                begin
                    pipe_next[k].np[i] = PW'($signed({1'b0, pipe_reg[k-1].a_root}))
                                       * PW'($signed(pipe_reg[k-1].n[i]));
                end
            end
        end
    end

    // final rounding, sum and saturation, zero vector on total reflection
    always_comb
    begin
        logic [PW-1:0]         pmag;
        logic [PW-1:0]         rq;
        logic signed [OW-1:0]  normv;
        logic signed [OW-1:0]  tang;
        logic signed [OW-1:0]  sum;
        for (int i = 0; i < 3; i++)
        begin
            pmag  = pipe_reg[NS-1].np[i][PW-1] ? -pipe_reg[NS-1].np[i]
                                               : pipe_reg[NS-1].np[i];
            rq    = (pmag + HALFP) >> F;
            normv = pipe_reg[NS-1].np[i][PW-1] ? -OW'(rq) : OW'(rq);
            if (pipe_reg[NS-1].len == '0)
            begin
                tang = '0;
            end
            else
            begin
                tang = pipe_reg[NS-1].tneg[i] ? -OW'(pipe_reg[NS-1].tq[i])
                                              : OW'(pipe_reg[NS-1].tq[i]);
            end
            sum = pipe_reg[NS-1].ext ? tang + normv : tang - normv;
            priority if (pipe_reg[NS-1].tir)
            begin
                out_next[i] = '0;
            end
            else if (sum > SAT_HI)
            begin
                out_next[i] = 16'h7fff;
            end
            else if (sum < SAT_LO)
            begin
                out_next[i] = 16'h8000;
            end
            else
            begin
                out_next[i] = 16'(sum);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NS; s++)
        begin
            pipe_reg[s] <= pipe_next[s];
        end
        out_x_reg         <= out_next[0];
        out_y_reg         <= out_next[1];
        out_z_reg         <= out_next[2];
        total_reflect_reg <= pipe_reg[NS-1].tir;
        exiting_reg       <= pipe_reg[NS-1].ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[NS-2:0], start & ~busy};
            done_reg  <= valid_reg[NS-1];
        end
    end

    assign done          = done_reg;
    assign out_x         = out_x_reg;
    assign out_y         = out_y_reg;
    assign out_z         = out_z_reg;
    assign total_reflect = total_reflect_reg;
    assign exiting       = exiting_reg;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(NS + 1) done)
        else $error("result missing after request");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, NS + 1))
        else $error("result without request");

    a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && total_reflect |-> out_x == 16'sd0 && out_y == 16'sd0 && out_z == 16'sd0)
        else $error("total reflection with nonzero vector");

    a_div1_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_S2-1] && !pipe_reg[ST_S2-1].ext && !pipe_reg[ST_S2-1].tir
        |-> pipe_reg[ST_S2-1].drem < NW'(pipe_reg[ST_S2-1].ior))
        else $error("sine divider remainder out of range");

    a_div2_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[ST_NP-1] && !pipe_reg[ST_NP-1].tir && pipe_reg[ST_NP-1].len != '0
        |-> pipe_reg[ST_NP-1].trem[0] < TW'(pipe_reg[ST_NP-1].len))
        else $error("tangent divider remainder out of range");
`endif

endmodule
